/* design/itp_pkg.sv */
// Shared types, character codes and precedence table for the infix-to-postfix converter.
package itp_pkg;

	localparam int unsigned ITP_STACK_DEPTH = 32;

	localparam logic [7:0] CH_NOT    = 8'h21;	// '!'
	localparam logic [7:0] CH_GT     = 8'h3E;	// '>'
	localparam logic [7:0] CH_LT     = 8'h3C;	// '<'
	localparam logic [7:0] CH_MOD    = 8'h25;	// '%'
	localparam logic [7:0] CH_AND    = 8'h26;	// '&'
	localparam logic [7:0] CH_OR     = 8'h7C;	// '|'
	localparam logic [7:0] CH_LPAREN = 8'h28;	// '('
	localparam logic [7:0] CH_RPAREN = 8'h29;	// ')'
	localparam logic [7:0] CH_LOW_A  = 8'h61;	// 'a'
	localparam logic [7:0] CH_LOW_Z  = 8'h7A;	// 'z'

	localparam logic [1:0] KIND_VAR  = 2'd0;
	localparam logic [1:0] KIND_OP   = 2'd1;
	localparam logic [1:0] KIND_TERM = 2'd2;

	localparam logic [7:0] CNT_MAX = 8'hFF;

	// shift command seen by every cell of the stack
	typedef struct packed {
		logic push;
		logic pop;
	} shift_t;

	// command from the sequencer to the stack
	typedef struct packed {
		logic       push;
		logic       pop;
		logic [7:0] din;
	} stk_ctrl_t;

	function automatic logic [2:0] prec_of(input logic [7:0] c);
		logic [2:0] p;
		case (c)
			CH_NOT:                 p = 3'd4;
			CH_GT, CH_LT, CH_MOD:   p = 3'd3;
			CH_AND, CH_OR:          p = 3'd2;
			default:                p = 3'd0;
		endcase
		return p;
	endfunction

endpackage

/* design/itp_cell.sv */
// One stack cell: holds one entry, takes the entry above on push, the one below on pop.
module itp_cell (
	input  logic           clk,
	input  itp_pkg::shift_t sh,
	input  logic [7:0]     from_above,
	input  logic [7:0]     from_below,
	output logic [7:0]     value
);
	import itp_pkg::*;

	logic [7:0] value_q;

	always_ff @(posedge clk) begin
		if (sh.push) begin
			value_q <= from_above;
		end else if (sh.pop) begin
			value_q <= from_below;
		end
	end

	assign value = value_q;

endmodule

/* design/itp_stack.sv */
// Operator stack as a row of shifting cells; cell 0 is the top of stack.
module itp_stack #(
	parameter int unsigned STACK_DEPTH = itp_pkg::ITP_STACK_DEPTH
) (
	input  logic              clk,
	input  itp_pkg::stk_ctrl_t ctrl,
	output logic [7:0]        top,
	output logic [7:0]        second
);
	import itp_pkg::*;

	logic [7:0] val [STACK_DEPTH];
	shift_t     sh;

	assign sh = '{push: ctrl.push, pop: ctrl.pop};

	for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
		logic [7:0] above;
		logic [7:0] below;
		if (g == 0) begin : g_first
			assign above = ctrl.din;
		end else begin : g_mid_a
			assign above = val[g-1];
		end
		if (g == STACK_DEPTH - 1) begin : g_last
			assign below = val[g];
		end else begin : g_mid_b
			assign below = val[g+1];
		end
		itp_cell u_cell (
			.clk        (clk),
			.sh         (sh),
			.from_above (above),
			.from_below (below),
			.value      (val[g])
		);
	end

	assign top    = val[0];
	assign second = val[1];

endmodule

/* design/infix_to_postfix_converter_top.sv */
// Top level: shunting-yard infix to postfix converter over a shifting cell stack.
// Input is registered and handled in S_WORK; result beats leave through an output register.
// A new item is taken only in S_IDLE, once the last is done; each popped and emitted entry
//   is a beat of its own, sent when the output register is free; dropping a '(' costs
//   nothing extra; a final item flushes every stacked entry and ends with the terminator beat.
// Reset (arst_n low, asynchronous): stack empty, counts and error flag cleared.
module infix_to_postfix_converter_top #(
	parameter int unsigned STACK_DEPTH = itp_pkg::ITP_STACK_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] character,
	input  logic       is_final,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] symbol,
	output logic [7:0] variable_number,
	output logic [7:0] total_count,
	output logic       stack_overflow,
	output logic       run_last
);
	import itp_pkg::*;

	localparam int unsigned FW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_WORK  = 3'b010,
		S_FLUSH = 3'b100
	} state_t;

	state_t     state_q, state_d;
	logic [7:0] char_q;
	logic       fin_q;
	logic [FW-1:0] fill_q;
	logic [7:0] emit_q;	// items emitted in this condition
	logic [7:0] var_q;	// next variable index
	logic       ovf_q;	// a push was dropped

	// output register
	logic       ov_q;
	logic [1:0] kind_q;
	logic [7:0] sym_q;
	logic [7:0] varn_q;
	logic [7:0] tot_q;
	logic       sovf_q;
	logic       last_q;

	// stack view
	stk_ctrl_t  sctl;
	logic [7:0] top_v;
	logic [7:0] nxt_v;

	itp_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
		.clk    (clk),
		.ctrl   (sctl),
		.top    (top_v),
		.second (nxt_v)
	);

	// decode of the held character and the stack top
	logic       is_letter, has, one_left, full, top_open, nxt_open;
	logic [2:0] p_in, p_top, p_nxt;
	logic       slot;	// output register free this cycle

	assign is_letter = (char_q >= CH_LOW_A) && (char_q <= CH_LOW_Z);
	assign has       = (fill_q != '0);
	assign one_left  = (fill_q == FW'(1));
	assign full      = (fill_q == FW'(STACK_DEPTH));
	assign top_open  = (top_v == CH_LPAREN);
	assign nxt_open  = (nxt_v == CH_LPAREN);
	assign p_in      = prec_of(char_q);
	assign p_top     = prec_of(top_v);
	assign p_nxt     = prec_of(nxt_v);
	assign slot      = !ov_q || out_ready;

	// sequencer decisions
	logic       do_emit, e_last, push_req, pop, var_inc, clr;
	logic [1:0] e_kind;
	logic [7:0] e_sym, e_var;
	logic [7:0] cnt_inc;

	assign cnt_inc = (emit_q == CNT_MAX) ? CNT_MAX : emit_q + 8'd1;

	always_comb begin
		state_d  = state_q;
		do_emit  = 1'b0;
		e_last   = 1'b0;
		e_kind   = KIND_OP;
		e_sym    = top_v;
		e_var    = '0;
		push_req = 1'b0;
		pop      = 1'b0;
		var_inc  = 1'b0;
		clr      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_WORK;
				end
			end
			S_WORK: begin
				if (is_letter) begin
					if (slot) begin
						do_emit = 1'b1;
						e_kind  = KIND_VAR;
						e_sym   = char_q;
						e_var   = var_q;
						e_last  = !fin_q;
						var_inc = 1'b1;
						state_d = fin_q ? S_FLUSH : S_IDLE;
					end
				end else if (char_q == CH_LPAREN) begin
					push_req = 1'b1;
					state_d  = fin_q ? S_FLUSH : S_IDLE;
				end else if (char_q == CH_RPAREN) begin
					if (has && !top_open) begin
						// pop down to the matching '('
						if (slot) begin
							do_emit = 1'b1;
							pop     = 1'b1;
							e_last  = !fin_q && (one_left || nxt_open);
						end
					end else begin
						pop     = has;	// drops the '('
						state_d = fin_q ? S_FLUSH : S_IDLE;
					end
				end else begin
					if (has && !top_open && (p_in <= p_top)) begin
						if (slot) begin
							do_emit = 1'b1;
							pop     = 1'b1;
							e_last  = !fin_q && (one_left || nxt_open || (p_in > p_nxt));
						end
					end else begin
						push_req = 1'b1;
						state_d  = fin_q ? S_FLUSH : S_IDLE;
					end
				end
			end
			S_FLUSH: begin
				if (slot) begin
					do_emit = 1'b1;
					if (has) begin
						pop = 1'b1;
					end else begin
						// terminator carries the final count
						e_kind  = KIND_TERM;
						e_sym   = '0;
						e_last  = 1'b1;
						clr     = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign sctl = '{push: push_req && !full, pop: pop, din: char_q};

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fin_q   <= 1'b0;
			fill_q  <= '0;
			emit_q  <= '0;
			var_q   <= '0;
			ovf_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				fin_q <= is_final;
			end
			if (clr) begin
				fill_q <= '0;
				emit_q <= '0;
				var_q  <= '0;
				ovf_q  <= 1'b0;
			end else begin
				if (push_req && !full) begin
					fill_q <= fill_q + FW'(1);
				end else if (pop) begin
					fill_q <= fill_q - FW'(1);
				end
				if (push_req && full) begin
					ovf_q <= 1'b1;
				end
				if (do_emit) begin
					emit_q <= cnt_inc;
				end
				if (var_inc && (var_q != CNT_MAX)) begin
					var_q <= var_q + 8'd1;
				end
			end
			if (do_emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_q <= character;
		end
		if (do_emit) begin
			kind_q <= e_kind;
			sym_q  <= e_sym;
			varn_q <= e_var;
			tot_q  <= (e_kind == KIND_TERM) ? emit_q : cnt_inc;
			sovf_q <= ovf_q;
			last_q <= e_last;
		end
	end

	assign out_valid       = ov_q;
	assign kind            = kind_q;
	assign symbol          = sym_q;
	assign variable_number = varn_q;
	assign total_count     = tot_q;
	assign stack_overflow  = sovf_q;
	assign run_last        = last_q;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(STACK_DEPTH))
		else $error("stack fill beyond depth");

	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_TERM)) |-> run_last)
		else $error("terminator beat without run_last");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item taken while one is in work");

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> (fill_q == '0) && (emit_q == '0) && !ovf_q)
		else $error("condition state not cleared after terminator");

endmodule

/* sim/itp_postfix_check_pkg.sv */
// Scoreboard for the infix-to-postfix converter: predicts postfix beats and checks them.
package itp_postfix_check_pkg;

	import itp_pkg::*;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] symbol;
		logic [7:0] var_no;
		logic [7:0] total;
		logic       overflow;
		logic       last;
	} postfix_beat_t;

	class postfix_scoreboard;
		postfix_beat_t postfix_due[$];
		logic [7:0]    op_stack [ITP_STACK_DEPTH];
		int unsigned   held = 0;
		logic [7:0]    emitted = 8'h00;
		logic [7:0]    next_var = 8'h00;
		logic          overflowed = 1'b0;
		int unsigned   errors = 0;
		int unsigned   beats_seen = 0;

		// binding strength of an operator byte
		static function int unsigned rank(input logic [7:0] c);
			case (c)
				CH_NOT:                 return 4;
				CH_GT, CH_LT, CH_MOD:   return 3;
				CH_AND, CH_OR:          return 2;
				default:                return 0;
			endcase
		endfunction

		function void queue_beat(input logic [1:0] k, input logic [7:0] s, input logic [7:0] v);
			if (emitted != CNT_MAX)
				emitted++;
			postfix_due.push_back(postfix_beat_t'{k, s, v, emitted, overflowed, 1'b0});
		endfunction

		function void pop_to_output();
			held--;
			queue_beat(KIND_OP, op_stack[held], 8'h00);
		endfunction

		function void push_op(input logic [7:0] c);
			if (held < ITP_STACK_DEPTH) begin
				op_stack[held] = c;
				held++;
			end else begin
				overflowed = 1'b1;
			end
		endfunction

		// works out every beat that one accepted character causes
		function void predict_postfix(input logic [7:0] c, input logic fin);
			int unsigned due_before;
			due_before = postfix_due.size();
			if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
				queue_beat(KIND_VAR, c, next_var);
				if (next_var != CNT_MAX)
					next_var++;
			end else if (c == CH_LPAREN) begin
				push_op(c);
			end else if (c == CH_RPAREN) begin
				while (held > 0 && op_stack[held - 1] != CH_LPAREN)
					pop_to_output();
				if (held > 0)
					held--;
			end else begin
				while (held > 0 && op_stack[held - 1] != CH_LPAREN &&
				       rank(c) <= rank(op_stack[held - 1]))
					pop_to_output();
				push_op(c);
			end
			if (fin) begin
				while (held > 0)
					pop_to_output();
				postfix_due.push_back(postfix_beat_t'{KIND_TERM, 8'h00, 8'h00, emitted,
				                                      overflowed, 1'b0});
				emitted = 8'h00;
				next_var = 8'h00;
				overflowed = 1'b0;
			end
			if (postfix_due.size() > due_before)
				postfix_due[postfix_due.size() - 1].last = 1'b1;
		endfunction

		function int unsigned due_count();
			return postfix_due.size();
		endfunction

		task note_mismatch(input string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		task check_field(input string name, input logic [7:0] got, input logic [7:0] want);
			if (got !== want)
				note_mismatch($sformatf("beat %0d %s got %0d want %0d", beats_seen, name,
				                        got, want));
		endtask

		task match_beat(input postfix_beat_t got);
			postfix_beat_t want;
			beats_seen++;
			if (postfix_due.size() == 0) begin
				note_mismatch($sformatf("beat %0d arrived with nothing due", beats_seen));
				return;
			end
			want = postfix_due.pop_front();
			check_field("kind", 8'(got.kind), 8'(want.kind));
			check_field("symbol", got.symbol, want.symbol);
			check_field("variable_number", got.var_no, want.var_no);
			check_field("total_count", got.total, want.total);
			check_field("stack_overflow", 8'(got.overflow), 8'(want.overflow));
			check_field("run_last", 8'(got.last), 8'(want.last));
		endtask
	endclass

endpackage

/* sim/tb_infix_to_postfix_converter_top.sv */
// Testbench for the infix-to-postfix converter: directed and random conditions, scoreboard check.
module tb_infix_to_postfix_converter_top;

	timeunit 1ns;
	timeprecision 1ps;

	import itp_pkg::*;
	import itp_postfix_check_pkg::*;

	localparam int unsigned HOLD_CYCLES  = 300;	// long receiver hold-off
	localparam int unsigned DRAIN_CYCLES = 40;	// quiet time once nothing is due
	localparam int unsigned RANDOM_ITEMS = 110;
	localparam int unsigned IDLE_PCT     = 38;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] character;
	logic       is_final;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] kind;
	logic [7:0] symbol;
	logic [7:0] variable_number;
	logic [7:0] total_count;
	logic       stack_overflow;
	logic       run_last;

	// steady: neither side idles; hold_req: asks the receiver for one long hold-off
	bit steady = 1'b0;
	bit hold_req = 1'b0;

	logic [7:0] text_q[$];	// condition being built, one byte per beat
	int unsigned random_sent;

	postfix_scoreboard sb = new();

	infix_to_postfix_converter_top #(
		.STACK_DEPTH(ITP_STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.character(character),
		.is_final(is_final),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.symbol(symbol),
		.variable_number(variable_number),
		.total_count(total_count),
		.stack_overflow(stack_overflow),
		.run_last(run_last)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#4ms;
		$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sender side. Every call starts at a falling edge; valid stays high
	// straight into the next beat unless the sender decides to idle.
	// ------------------------------------------------------------------
	function automatic bit sender_idles();
		return !steady && ($urandom_range(0, 99) < IDLE_PCT);
	endfunction

	task automatic send_char(input logic [7:0] c, input logic fin);
		while (sender_idles()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		character <= c;
		is_final  <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.predict_postfix(c, fin);
		@(negedge clk);
	endtask

	// sends the built condition, last byte flagged final
	task automatic send_text();
		int unsigned i;
		if (text_q.size() == 0)
			text_q.push_back(CH_LOW_A);
		for (i = 0; i < text_q.size(); i++)
			send_char(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	task automatic send_cond(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
		send_text();
	endtask

	// ------------------------------------------------------------------
	// Condition builders
	// ------------------------------------------------------------------
	function automatic logic [7:0] any_letter();
		return 8'(CH_LOW_A + $urandom_range(0, 25));
	endfunction

	// a byte that is taken as an operator: neither a letter nor a paren
	function automatic logic [7:0] odd_operator();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while ((c >= CH_LOW_A && c <= CH_LOW_Z) || c == CH_LPAREN || c == CH_RPAREN);
		return c;
	endfunction

	function automatic logic [7:0] binary_op();
		case ($urandom_range(0, 9))
			0:       return CH_GT;
			1:       return CH_LT;
			2:       return CH_MOD;
			3, 4:    return CH_AND;
			5, 6:    return CH_OR;
			7:       return CH_NOT;
			default: return odd_operator();
		endcase
	endfunction

	function automatic void add_operand(input int unsigned lvl);
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (lvl < 4 && pick < 2) begin
			text_q.push_back(CH_LPAREN);
			add_expr(lvl + 1);
			text_q.push_back(CH_RPAREN);
		end else if (lvl < 6 && pick < 4) begin
			text_q.push_back(CH_NOT);
			add_operand(lvl + 1);
		end else begin
			text_q.push_back(any_letter());
		end
	endfunction

	function automatic void add_expr(input int unsigned lvl);
		int unsigned terms;
		terms = $urandom_range(1, 4);
		add_operand(lvl);
		repeat (terms - 1) begin
			text_q.push_back(binary_op());
			add_operand(lvl);
		end
	endfunction

	// one slip in an otherwise sound condition
	function automatic void break_text();
		int unsigned pos;
		pos = $urandom_range(0, text_q.size() - 1);
		case ($urandom_range(0, 3))
			0:       text_q.delete(pos);
			1:       text_q[pos] = 8'($urandom_range(0, 255));
			2:       text_q.insert(pos, CH_RPAREN);
			default: text_q.insert(pos, CH_LPAREN);
		endcase
	endfunction

	// nesting that can be deep enough to fill the stack, so the flush is at its longest
	function automatic void build_deep(input int unsigned opens);
		repeat (opens)
			text_q.push_back(CH_LPAREN);
		add_expr(2);
		repeat ($urandom_range(0, 3))
			text_q.push_back(CH_RPAREN);
	endfunction

	function automatic void build_random();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			add_expr(0);
		end else if (roll < 82) begin
			repeat ($urandom_range(1, 10))
				text_q.push_back(8'($urandom_range(0, 255)));
		end else if (roll < 96) begin
			add_expr(0);
			break_text();
		end else begin
			build_deep($urandom_range(26, 36));
		end
	endfunction

	// ------------------------------------------------------------------
	// Receiver side: random back-pressure, plus one long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
			end
			out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// every result beat goes to the scoreboard as it is taken
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.match_beat(postfix_beat_t'{kind, symbol, variable_number, total_count,
			                              stack_overflow, run_last});
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		character = 8'h00;
		is_final  = 1'b0;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: lone variable, every operator at mixed precedence,
		// letter boundaries and the zero and all-ones bytes as operators,
		// then a stray close paren followed by an open paren left for the flush.
		send_cond("a");
		send_cond("a>b&!c|d<e%f");
		send_char(CH_LOW_Z, 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'(CH_LOW_A - 1), 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'(CH_LOW_Z + 1), 1'b1);
		send_cond("a&b)(c");

		// Full stack: pushes beyond the depth are dropped, then the longest flush.
		build_deep(34);
		send_text();
		build_deep($urandom_range(28, 35));
		send_text();

		// Random conditions; a stretch in the middle runs with no idling.
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			steady = (random_sent >= 40 && random_sent < 80);
			build_random();
			random_sent += text_q.size();
			send_text();
		end
		steady = 1'b0;

		// Back-pressure: the receiver stalls for a long stretch while the
		// sender keeps offering beats, so the block fills and holds off input.
		hold_req = 1'b1;
		steady   = 1'b1;
		random_sent = 0;
		while (random_sent < 40) begin
			add_expr(0);
			random_sent += text_q.size();
			send_text();
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		// drain: wait for every due beat, then a quiet spell for stragglers
		while (sb.due_count() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		@(negedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
